// ===== src/difference_hash_9x8_assert.svh =====
// ---------------------------------------------------------------------------
// difference_hash_9x8 assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ---------------------------------------------------------------------------
`ifndef DIFFERENCE_HASH_9X8_ASSERT_SVH
`define DIFFERENCE_HASH_9X8_ASSERT_SVH

`ifndef ASSERT_OFF

// cond must never hold out of reset
`define DH_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("dhash assertion failed: never");

// b must hold in the cycle where a holds
`define DH_ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("dhash assertion failed: implication");

// b must hold in the cycle after a holds
`define DH_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("dhash assertion failed: next cycle");

`else

`define DH_ASSERT_NEVER(label, clk, rst_n, cond)
`define DH_ASSERT_IMPL(label, clk, rst_n, a, b)
`define DH_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== src/dh98_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dh98_pkg
// Shared constants and sample-position functions of the difference hash.
// ---------------------------------------------------------------------------
package dh98_pkg;

	localparam int DEFAULT_MAX_DIMENSION = 8192;
	localparam int RESET_DIMENSION       = 64;
	localparam int GRID_COLUMNS          = 9;
	localparam int GRID_ROWS             = 8;
	localparam int CFG_W                 = 14;
	localparam int PIX_W                 = 8;
	localparam int GRAY_W                = 18;
	localparam int HASH_W                = GRID_COLUMNS * GRID_ROWS - GRID_ROWS;
	localparam int NEXT_W                = 4;

	// luma weights, scaled by 1000
	localparam logic [9:0] WEIGHT_RED   = 10'd299;
	localparam logic [9:0] WEIGHT_GREEN = 10'd587;
	localparam logic [9:0] WEIGHT_BLUE  = 10'd114;

	// register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// x / 9 as (x * COL_RECIP) >> COL_SHIFT, exact for x < 2**21
	localparam int         COL_SHIFT = 24;
	localparam logic [20:0] COL_RECIP = 21'd1864136;
	// rows: divide by 2 * GRID_ROWS
	localparam int         ROW_SHIFT = 4;

	// pixel column of sample column k: floor((2k+1) * dim / 18)
	function automatic logic [14:0] col_pixel(input logic [3:0] k, input logic [14:0] dim);
		logic [19:0] m;
		logic [18:0] n;
		logic [43:0] p;
		m = 20'({k, 1'b1}) * 20'(dim);
		n = m[19:1];
		p = 44'(n) * 44'(COL_RECIP);
		return 15'(p >> COL_SHIFT);
	endfunction

	// pixel row of sample row j: floor((2j+1) * dim / 16)
	function automatic logic [14:0] row_pixel(input logic [3:0] j, input logic [14:0] dim);
		logic [19:0] m;
		m = 20'({j, 1'b1}) * 20'(dim);
		return 15'(m >> ROW_SHIFT);
	endfunction

endpackage

// ===== src/dh98_grid.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dh98_grid
// Image size registers and registered sample-grid positions.
// ---------------------------------------------------------------------------
module dh98_grid import dh98_pkg::*; #(
	parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION,
	localparam int DIM_W = $clog2(MAX_DIMENSION + 1),
	localparam int POS_W = $clog2(MAX_DIMENSION)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output logic [DIM_W-1:0] width,
	output logic [DIM_W-1:0] height,
	output logic [POS_W-1:0] col_tgt [GRID_COLUMNS],
	output logic [POS_W-1:0] row_tgt [GRID_ROWS]
);

	localparam int RST_DIM = (RESET_DIMENSION > MAX_DIMENSION) ? MAX_DIMENSION
		: RESET_DIMENSION;

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [POS_W-1:0] col_tgt_q [GRID_COLUMNS];
	logic [POS_W-1:0] row_tgt_q [GRID_ROWS];
	logic [DIM_W-1:0] dim_clamped;

	// zero reads as one, oversize as the maximum
	always_comb begin
		priority if (cfg_data == '0) begin
			dim_clamped = DIM_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_DIMENSION)) begin
			dim_clamped = DIM_W'(MAX_DIMENSION);
		end else begin
			dim_clamped = DIM_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(RST_DIM);
			height_q <= DIM_W'(RST_DIM);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= dim_clamped;
				REG_IMAGE_HEIGHT: height_q <= dim_clamped;
				default:          width_q  <= width_q;
			endcase
		end
	end

	// positions are registered from the size registers and follow them in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < GRID_COLUMNS; k++)
				col_tgt_q[k] <= POS_W'(col_pixel(4'(k), 15'(RST_DIM)));
			for (int j = 0; j < GRID_ROWS; j++)
				row_tgt_q[j] <= POS_W'(row_pixel(4'(j), 15'(RST_DIM)));
		end else begin
			for (int k = 0; k < GRID_COLUMNS; k++)
				col_tgt_q[k] <= POS_W'(col_pixel(4'(k), 15'(width_q)));
			for (int j = 0; j < GRID_ROWS; j++)
				row_tgt_q[j] <= POS_W'(row_pixel(4'(j), 15'(height_q)));
		end
	end

	assign width   = width_q;
	assign height  = height_q;
	assign col_tgt = col_tgt_q;
	assign row_tgt = row_tgt_q;

endmodule

// ===== src/dh98_accum.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dh98_accum
// Raster position, sampled row grays and hash accumulation.
// ---------------------------------------------------------------------------
`include "difference_hash_9x8_assert.svh"

module dh98_accum import dh98_pkg::*; #(
	parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION,
	localparam int DIM_W = $clog2(MAX_DIMENSION + 1),
	localparam int POS_W = $clog2(MAX_DIMENSION)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [GRAY_W-1:0] gray,
	input  logic [DIM_W-1:0]  width,
	input  logic [DIM_W-1:0]  height,
	input  logic [POS_W-1:0]  col_tgt [GRID_COLUMNS],
	input  logic [POS_W-1:0]  row_tgt [GRID_ROWS],
	output logic              result,
	output logic [HASH_W-1:0] hash
);

	localparam int CMP_W = DIM_W + 1;

	logic [POS_W-1:0]  col_q;
	logic [POS_W-1:0]  row_q;
	logic [NEXT_W-1:0] next_q;
	logic [HASH_W-1:0] hash_q;
	logic [GRAY_W-1:0] grays_q [GRID_COLUMNS];

	logic [GRAY_W-1:0]      grays_n [GRID_COLUMNS];
	logic [GRID_COLUMNS-2:0] bits;
	logic [GRID_ROWS-1:0]   reached;
	logic [NEXT_W-1:0]      reached_cnt;
	logic [NEXT_W-1:0]      next_n;
	logic [HASH_W-1:0]      hash_n;
	logic                   row_end;
	logic                   img_end;
	logic                   hash_ahead_nz;

	always_comb begin
		for (int k = 0; k < GRID_COLUMNS; k++)
			grays_n[k] = (col_q == col_tgt[k]) ? gray : grays_q[k];
		for (int x = 0; x < GRID_COLUMNS - 1; x++)
			bits[x] = grays_n[x] > grays_n[x + 1];

		row_end = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(width);
		img_end = row_end && ((CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(height));

		// sample rows reached so far; positions rise with j
		reached_cnt = '0;
		for (int j = 0; j < GRID_ROWS; j++) begin
			reached[j]  = row_tgt[j] <= row_q;
			reached_cnt = reached_cnt + NEXT_W'(reached[j]);
		end
		next_n = (reached_cnt > next_q) ? reached_cnt : next_q;

		hash_n = hash_q;
		for (int j = 0; j < GRID_ROWS; j++)
			if (reached[j] && (NEXT_W'(j) >= next_q))
				hash_n[j*8 +: 8] = hash_n[j*8 +: 8] | bits;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int k = 0; k < GRID_COLUMNS; k++)
				grays_q[k] <= grays_n[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			next_q <= '0;
			hash_q <= '0;
		end else if (advance) begin
			priority if (!row_end) begin
				col_q <= col_q + POS_W'(1);
			end else if (img_end) begin
				col_q  <= '0;
				row_q  <= '0;
				next_q <= '0;
				hash_q <= '0;
			end else begin
				col_q  <= '0;
				row_q  <= row_q + POS_W'(1);
				next_q <= next_n;
				hash_q <= hash_n;
			end
		end
	end

	assign result = advance && img_end;
	assign hash   = ((width <= DIM_W'(1)) || (height <= DIM_W'(1))) ? '0 : hash_n;

	// rows not yet formed hold no set bits
	assign hash_ahead_nz = (next_q < NEXT_W'(GRID_ROWS)) &&
		((hash_q >> (6'(next_q) * 6'd8)) != '0);

	`DH_ASSERT_NEVER(a_next_range, clk, arst_n, next_q > NEXT_W'(GRID_ROWS))
	`DH_ASSERT_NEVER(a_hash_ahead_clear, clk, arst_n, hash_ahead_nz)
	`DH_ASSERT_NEXT(a_clear_after_image, clk, arst_n, result, (col_q == '0) && (row_q == '0) && (next_q == '0) && (hash_q == '0))
	`DH_ASSERT_IMPL(a_result_row_end, clk, arst_n, result, row_end && advance)

endmodule

// ===== src/difference_hash_9x8.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// difference_hash_9x8
// Streaming 64-bit difference hash (dHash) of each RGB image.
// ---------------------------------------------------------------------------
// Pixels come in raster order, one request per pixel on the slave stream, and
// one request carrying the 64-bit hash leaves on the master stream after the
// last pixel of each image. A pixel is taken every cycle when the output side
// keeps up. The gray value is formed ahead of the input register, and the
// position / compare logic sits between the input register and the result
// register. The hash is therefore offered on the master stream once its last
// pixel has passed the input register and the result register.
// While a finished hash waits for m_axis_tready the input register still takes
// one more pixel, then holds.
// Image size is set by cfg_we / cfg_index / cfg_data (0 width, 1 height);
// 0 counts as 1, values above MAX_DIMENSION as MAX_DIMENSION, and a width or
// height of one gives a hash of zero. Write the size only between images, and
// take no pixel at the edge of the write; the first pixel may be taken at the
// next edge after the last write.
// ---------------------------------------------------------------------------
module difference_hash_9x8 import dh98_pkg::*; #(
	parameter int MAX_DIMENSION = DEFAULT_MAX_DIMENSION
) (
	input  logic              clk,
	input  logic              arst_n,
	// slave stream: pixels
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [23:0]       s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
	// master stream: hash
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [HASH_W-1:0] m_axis_tdata,   // image_hash [63:0]
	// configuration writes
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int POS_W = $clog2(MAX_DIMENSION);

	logic [PIX_W-1:0]  red;
	logic [PIX_W-1:0]  green;
	logic [PIX_W-1:0]  blue;
	logic [GRAY_W-1:0] gray;

	logic              valid_s1;
	logic [GRAY_W-1:0] gray_s1;
	logic              advance;

	logic              out_valid_q;
	logic [HASH_W-1:0] out_hash_q;

	logic [DIM_W-1:0]  width;
	logic [DIM_W-1:0]  height;
	logic [POS_W-1:0]  col_tgt [GRID_COLUMNS];
	logic [POS_W-1:0]  row_tgt [GRID_ROWS];
	logic              result;
	logic [HASH_W-1:0] hash;

	assign red   = s_axis_tdata[7:0];
	assign green = s_axis_tdata[15:8];
	assign blue  = s_axis_tdata[23:16];

	// luma scaled by 1000, exact
	assign gray = GRAY_W'(WEIGHT_RED) * GRAY_W'(red)
		+ GRAY_W'(WEIGHT_GREEN) * GRAY_W'(green)
		+ GRAY_W'(WEIGHT_BLUE) * GRAY_W'(blue);

	// stage 1 moves on only when the result register is free
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			gray_s1 <= gray;
		end
	end

	dh98_grid #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_grid (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.width    (width),
		.height   (height),
		.col_tgt  (col_tgt),
		.row_tgt  (row_tgt)
	);

	dh98_accum #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.gray   (gray_s1),
		.width  (width),
		.height (height),
		.col_tgt(col_tgt),
		.row_tgt(row_tgt),
		.result (result),
		.hash   (hash)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && result) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result) begin
			out_hash_q <= hash;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_hash_q;

endmodule
